// ----- sv/rqs_pkg.sv -----
// Package of the ready queue scheduler: sizes, codes, entry type and the
// command and status structs between controller and datapath. No dependencies.
package rqs_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int TIME_W      = 24;
  localparam int CFG_W       = 16;
  localparam int DONE_W      = 16;

  // Policy codes.
  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_RR   = 2'd1;
  localparam logic [1:0] POL_SJF  = 2'd2;
  localparam logic [1:0] POL_PSJF = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_GRANTED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_POLICY  = 2'd0;
  localparam logic [1:0] REG_QUANTUM = 2'd1;
  localparam logic [1:0] REG_UNIT    = 2'd2;

  localparam logic [CFG_W-1:0] QUANTUM_RESET = 16'd500;
  localparam logic [CFG_W-1:0] UNIT_RESET    = 16'd100;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] rem;
  } entry_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REJECT,
    OP_APPEND,
    OP_RD_PREV,
    OP_SHIFT,
    OP_RD_HEAD,
    OP_CLOSE_ROT,
    OP_RD_TAIL,
    OP_CLOSE_TAIL,
    OP_CLEAR_SLICE,
    OP_EMPTY,
    OP_GRANT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic sjf;
    logic slice_open;
    logic rot_ok;
    logic shift;
    logic pos_zero;
    logic out_busy;
  } stat_t;

  // Physical slot of a logical queue position in the circular buffer.
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(ofs);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- sv/rqs_if.sv -----
// Handshake interfaces of the ready queue scheduler: input, result and
// configuration channels. Depends on rqs_pkg.
interface rqs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [rqs_pkg::ID_W-1:0]   process_id;
  logic [rqs_pkg::TIME_W-1:0] exec_time;
  modport source (output valid, action, process_id, exec_time, input ready);
  modport sink   (input valid, action, process_id, exec_time, output ready);
endinterface

interface rqs_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [rqs_pkg::ID_W-1:0]   granted_id;
  logic [rqs_pkg::TIME_W-1:0] slice_length;
  logic                       switched;
  logic [rqs_pkg::DONE_W-1:0] jobs_done;
  modport source (output valid, status, granted_id, slice_length, switched, jobs_done,
                  input ready);
  modport sink   (input valid, status, granted_id, slice_length, switched, jobs_done,
                  output ready);
endinterface

interface rqs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                index;
  logic [rqs_pkg::CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/rqs_ctrl.sv -----
// Controller of the ready queue scheduler: sequences arrivals and dispatches
// into datapath operations. Depends on rqs_pkg.
module rqs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_action_i,
  output logic           in_ready_o,
  input  rqs_pkg::stat_t stat_i,
  output rqs_pkg::cmd_t  cmd_o
);
  import rqs_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ARR   = 4'd1;
  localparam logic [3:0] S_ACMP  = 4'd2;
  localparam logic [3:0] S_DISP  = 4'd3;
  localparam logic [3:0] S_DHEAD = 4'd4;
  localparam logic [3:0] S_DTAIL = 4'd5;
  localparam logic [3:0] S_GRANT = 4'd6;
  localparam logic [3:0] S_GHEAD = 4'd7;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.out_busy;

  // Next state and operation.
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.op = OP_LOAD;
          state_d  = in_action_i ? S_DISP : S_ARR;
        end
      end
      S_ARR: begin
        if (stat_i.full) begin
          cmd_o.op = OP_REJECT;
          state_d  = S_IDLE;
        end else if (stat_i.sjf && !stat_i.pos_zero) begin
          cmd_o.op = OP_RD_PREV;
          state_d  = S_ACMP;
        end else begin
          cmd_o.op = OP_APPEND;
          state_d  = S_IDLE;
        end
      end
      S_ACMP: begin
        if (stat_i.shift) begin
          cmd_o.op = OP_SHIFT;
          state_d  = S_ARR;
        end else begin
          cmd_o.op = OP_APPEND;
          state_d  = S_IDLE;
        end
      end
      S_DISP: begin
        if (stat_i.slice_open && !stat_i.empty) begin
          cmd_o.op = OP_RD_HEAD;
          state_d  = S_DHEAD;
        end else begin
          if (stat_i.slice_open) begin
            cmd_o.op = OP_CLEAR_SLICE;
          end
          state_d = S_GRANT;
        end
      end
      S_DHEAD: begin
        if (stat_i.rot_ok) begin
          cmd_o.op = OP_CLOSE_ROT;
          state_d  = S_GRANT;
        end else begin
          cmd_o.op = OP_RD_TAIL;
          state_d  = S_DTAIL;
        end
      end
      S_DTAIL: begin
        cmd_o.op = OP_CLOSE_TAIL;
        state_d  = S_GRANT;
      end
      S_GRANT: begin
        if (stat_i.empty) begin
          cmd_o.op = OP_EMPTY;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_RD_HEAD;
          state_d  = S_GHEAD;
        end
      end
      S_GHEAD: begin
        cmd_o.op = OP_GRANT;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/rqs_dp.sv -----
// Datapath of the ready queue scheduler: circular queue memory, counters,
// configuration registers and result register. Depends on rqs_pkg, rqs_if.
module rqs_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [rqs_pkg::ID_W-1:0]   in_id_i,
  input  logic [rqs_pkg::TIME_W-1:0] in_time_i,
  input  rqs_pkg::cmd_t             cmd_i,
  output rqs_pkg::stat_t            stat_o,
  rqs_out_if.source                 out_o,
  rqs_cfg_if.sink                   cfg_i
);
  import rqs_pkg::*;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rd_q, new_q, wr_data;
  logic   wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr, head_q;
  logic [CNT_W-1:0] count_q, pos_q;
  logic [DONE_W-1:0] retired_q;
  logic [ID_W-1:0]   last_id_q;
  logic grant_valid_q, slice_open_q;
  logic [1:0]       policy_q;
  logic [CFG_W-1:0] quantum_q, unit_q, lim;
  logic [TIME_W-1:0] slice;
  logic out_valid_q;
  logic [1:0]        o_status_q;
  logic [ID_W-1:0]   o_id_q;
  logic [TIME_W-1:0] o_slice_q;
  logic              o_sw_q;
  logic              retire;

  // Status toward the controller.
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.sjf        = policy_q[1];
  assign stat_o.slice_open = slice_open_q;
  assign stat_o.rot_ok     = (policy_q != POL_PSJF) || (rd_q.rem == '0);
  assign stat_o.shift      = (new_q.rem < rd_q.rem);
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.out_busy   = out_valid_q;

  // Slice length for the head job.
  always_comb begin
    lim = (policy_q == POL_RR) ? quantum_q : unit_q;
    if (lim == '0) begin
      lim = CFG_W'(1);
    end
    if (policy_q == POL_RR || policy_q == POL_PSJF) begin
      slice = (rd_q.rem > TIME_W'(lim)) ? TIME_W'(lim) : rd_q.rem;
    end else begin
      slice = rd_q.rem;
    end
  end

  // Memory port addressing.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys_idx(head_q, pos_q);
    wr_data = new_q;
    rd_en   = 1'b0;
    rd_addr = head_q;
    case (cmd_i.op)
      OP_APPEND: begin
        wr_en = 1'b1;
      end
      OP_SHIFT: begin
        wr_en   = 1'b1;
        wr_data = rd_q;
      end
      OP_CLOSE_ROT: begin
        wr_en   = 1'b1;
        wr_addr = phys_idx(head_q, count_q);
        wr_data = rd_q;
      end
      OP_GRANT: begin
        wr_en   = 1'b1;
        wr_addr = head_q;
        wr_data = '{id: rd_q.id, rem: rd_q.rem - slice};
      end
      OP_RD_PREV: begin
        rd_en   = 1'b1;
        rd_addr = phys_idx(head_q, pos_q - CNT_W'(1));
      end
      OP_RD_HEAD: begin
        rd_en = 1'b1;
      end
      OP_RD_TAIL: begin
        rd_en   = 1'b1;
        rd_addr = phys_idx(head_q, count_q - CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  assign retire = ((cmd_i.op == OP_CLOSE_ROT) || (cmd_i.op == OP_CLOSE_TAIL)) &&
                  (rd_q.rem == '0);

  // Queue memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Arriving word and insertion position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      new_q <= '{id: in_id_i, rem: in_time_i};
      pos_q <= count_q;
    end else if (cmd_i.op == OP_SHIFT) begin
      pos_q <= pos_q - CNT_W'(1);
    end
  end

  // Queue control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      count_q       <= '0;
      retired_q     <= '0;
      last_id_q     <= '0;
      grant_valid_q <= 1'b0;
      slice_open_q  <= 1'b0;
    end else begin
      if (cmd_i.op == OP_APPEND) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.op == OP_CLOSE_ROT) begin
        head_q <= phys_idx(head_q, CNT_W'(1));
      end
      if (retire) begin
        count_q <= count_q - CNT_W'(1);
        if (retired_q != '1) begin
          retired_q <= retired_q + DONE_W'(1);
        end
      end
      if ((cmd_i.op == OP_CLOSE_ROT) || (cmd_i.op == OP_CLOSE_TAIL) ||
          (cmd_i.op == OP_CLEAR_SLICE)) begin
        slice_open_q <= 1'b0;
      end
      if (cmd_i.op == OP_GRANT) begin
        last_id_q     <= rd_q.id;
        grant_valid_q <= 1'b1;
        slice_open_q  <= 1'b1;
      end
    end
  end

  // Configuration registers; writes are always taken.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POL_FIFO;
      quantum_q <= QUANTUM_RESET;
      unit_q    <= UNIT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_POLICY:  policy_q  <= cfg_i.data[1:0];
        REG_QUANTUM: quantum_q <= cfg_i.data;
        REG_UNIT:    unit_q    <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.op == OP_REJECT) || (cmd_i.op == OP_APPEND) ||
                 (cmd_i.op == OP_EMPTY) || (cmd_i.op == OP_GRANT)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result word payload.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_REJECT, OP_APPEND, OP_EMPTY: begin
        o_status_q <= (cmd_i.op == OP_REJECT) ? ST_FULL :
                      (cmd_i.op == OP_APPEND) ? ST_ACCEPTED : ST_EMPTY;
        o_id_q     <= '0;
        o_slice_q  <= '0;
        o_sw_q     <= 1'b0;
      end
      OP_GRANT: begin
        o_status_q <= ST_GRANTED;
        o_id_q     <= rd_q.id;
        o_slice_q  <= slice;
        o_sw_q     <= !grant_valid_q || (rd_q.id != last_id_q);
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = o_status_q;
  assign out_o.granted_id   = o_id_q;
  assign out_o.slice_length = o_slice_q;
  assign out_o.switched     = o_sw_q;
  assign out_o.jobs_done    = retired_q;

endmodule

// ----- sv/ready_queue_scheduler.sv -----
// Ready queue scheduler: FIFO, round robin, SJF and preemptive SJF policies.
// Arrival: load, then append, or reject when full; under SJF each step first reads the
// previous entry and shifts it back one place while the new job is shorter.
// A new word is taken only when the sequencer is idle and the previous result has drained.
// Reset: asynchronous active low; queue empty, counters zero, registers at defaults.
// Depends on rqs_pkg, rqs_if, rqs_ctrl, rqs_dp.
module ready_queue_scheduler (
  input  logic       clk_i,
  input  logic       rst_ni,
  rqs_in_if.sink     in_i,
  rqs_out_if.source  out_o,
  rqs_cfg_if.sink    cfg_i
);
  import rqs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rqs_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_id_i   (in_i.process_id),
    .in_time_i (in_i.exec_time),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_o     (out_o),
    .cfg_i     (cfg_i)
  );

endmodule
